### hdl/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment display driver package
// Shared types, constants and the digit-to-segment map for the display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Buffer geometry.
  localparam int ROW_COUNT   = 8;
  localparam int ROW_IDX_W   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int FRAME_COUNT = 5 + ROW_COUNT;
  localparam int FRAME_W     = $clog2(FRAME_COUNT);

  // Command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operation codes.
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_PRINT   = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;

  // Display controller register addresses.
  localparam logic [3:0] ADDR_DECODE    = 4'h9;
  localparam logic [3:0] ADDR_INTENSITY = 4'hA;
  localparam logic [3:0] ADDR_SCANLIMIT = 4'hB;
  localparam logic [3:0] ADDR_SHUTDOWN  = 4'hC;
  localparam logic [3:0] ADDR_DISPTEST  = 4'hF;

  // Configuration register indexes (taken from paddr bit 2).
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_SCAN_LIMIT = 1'b1;

  // Reciprocal of ten for exact division of 16-bit values.
  localparam logic [15:0] RECIP_TEN  = 16'd52429;
  localparam int          RECIP_SHFT = 19;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] number;
    logic [2:0]  end_position;
  } in_item_t;

  typedef struct packed {
    logic [3:0] register_address;
    logic [7:0] register_data;
    logic       last_frame;
  } out_item_t;

  // Settings seen by the back part.
  typedef struct packed {
    logic [3:0] brightness;
    logic [2:0] scan_limit;
  } cfg_t;

  // Queue write side.
  typedef struct packed {
    logic     push;
    in_item_t item;
  } push_t;

  // Queue read side.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } head_t;

  // Segment pattern of one decimal digit; bit 6 is segment A.
  function automatic logic [7:0] seg_of_digit(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'b0111_1110;
      4'd1:    seg = 8'b0011_0000;
      4'd2:    seg = 8'b0110_1101;
      4'd3:    seg = 8'b0111_1001;
      4'd4:    seg = 8'b0011_0011;
      4'd5:    seg = 8'b0101_1011;
      4'd6:    seg = 8'b0101_1111;
      4'd7:    seg = 8'b0111_0010;
      4'd8:    seg = 8'b0111_1111;
      4'd9:    seg = 8'b0111_1011;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

### hdl/ssd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display driver front end
// Accepts input transactions, drops unused operation codes and hands the
// rest to the command queue through a holding register.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ssd_pkg::in_item_t in_data,
  input  logic             queue_full,
  output ssd_pkg::push_t   push
);

  logic              hold_valid_r, hold_valid_nxt;
  ssd_pkg::in_item_t hold_item_r;
  logic              accept;
  logic              known_op;
  logic              push_ok;

  // The holding register drains into the queue whenever there is room.
  assign push_ok  = hold_valid_r && !queue_full;
  assign in_stall = hold_valid_r && queue_full;
  assign accept   = in_valid && !in_stall;

  // Only clear, print and refresh carry any work.
  always_comb begin
    unique case (in_data.operation)
      ssd_pkg::OP_CLEAR, ssd_pkg::OP_PRINT, ssd_pkg::OP_REFRESH: known_op = 1'b1;
      default:                                                   known_op = 1'b0;
    endcase
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (push_ok) begin
      hold_valid_nxt = 1'b0;
    end
    if (accept && known_op) begin
      hold_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && known_op) begin
      hold_item_r <= in_data;
    end
  end

  assign push.push = push_ok;
  assign push.item = hold_item_r;

endmodule

### hdl/ssd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display driver command queue
// Short first-in first-out queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module ssd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  ssd_pkg::push_t push,
  output logic           full,
  output ssd_pkg::head_t head,
  input  logic           pop
);

  ssd_pkg::in_item_t                     entry_r [ssd_pkg::QUEUE_DEPTH];
  logic [ssd_pkg::QUEUE_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ssd_pkg::QUEUE_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ssd_pkg::QUEUE_CNT_W-1:0]       count_r, count_nxt;
  logic                                  do_push;
  logic                                  do_pop;

  assign full    = (count_r == ssd_pkg::QUEUE_CNT_W'(ssd_pkg::QUEUE_DEPTH));
  assign do_push = push.push && !full;
  assign do_pop  = pop && (count_r != '0);

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ssd_pkg::QUEUE_PTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ssd_pkg::QUEUE_PTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.item;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.item  = entry_r[rd_ptr_r];

endmodule

### hdl/ssd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display driver back end
// Holds the segment buffer and carries out clear, print and refresh
// commands taken from the queue; refresh frames leave through an output
// register.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ssd_pkg::head_t     head,
  output logic               pop,
  input  ssd_pkg::cfg_t      cfg,
  output logic               out_valid,
  input  logic               out_stall,
  output ssd_pkg::out_item_t out_data
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PRINT   = 2'd1;
  localparam logic [1:0] ST_REFRESH = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [7:0]                    rows_r [ssd_pkg::ROW_COUNT];
  logic [15:0]                   num_r, num_nxt;
  logic [2:0]                    pos_r, pos_nxt;
  logic [ssd_pkg::FRAME_W-1:0]   frame_r, frame_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ssd_pkg::out_item_t            out_data_r;

  logic [31:0]                   recip_prod;
  logic [15:0]                   quot;
  logic [15:0]                   rem_full;
  logic [3:0]                    digit;
  logic                          row_write;
  logic                          rows_clear;
  logic                          frame_load;
  logic                          frame_last;
  logic [ssd_pkg::FRAME_W-1:0]   row_sel;
  ssd_pkg::out_item_t            frame;

  // One decimal digit per cycle: quotient by reciprocal multiply.
  assign recip_prod = num_r * ssd_pkg::RECIP_TEN;
  assign quot       = 16'(recip_prod >> ssd_pkg::RECIP_SHFT);
  assign rem_full   = num_r - ((quot << 3) + (quot << 1));
  assign digit      = rem_full[3:0];
  assign row_write  = (state_r == ST_PRINT) && (int'(pos_r) < ssd_pkg::ROW_COUNT);

  // Frame contents by position in the refresh sequence.
  assign row_sel    = ssd_pkg::FRAME_W'(ssd_pkg::ROW_COUNT + 4) - frame_r;
  assign frame_last = (frame_r == ssd_pkg::FRAME_W'(ssd_pkg::FRAME_COUNT - 1));

  always_comb begin
    frame.last_frame = frame_last;
    case (frame_r)
      ssd_pkg::FRAME_W'(0): begin
        frame.register_address = ssd_pkg::ADDR_DECODE;
        frame.register_data    = 8'h00;
      end
      ssd_pkg::FRAME_W'(1): begin
        frame.register_address = ssd_pkg::ADDR_INTENSITY;
        frame.register_data    = {4'h0, cfg.brightness};
      end
      ssd_pkg::FRAME_W'(2): begin
        frame.register_address = ssd_pkg::ADDR_SCANLIMIT;
        frame.register_data    = {5'h00, cfg.scan_limit};
      end
      ssd_pkg::FRAME_W'(3): begin
        frame.register_address = ssd_pkg::ADDR_SHUTDOWN;
        frame.register_data    = 8'h01;
      end
      ssd_pkg::FRAME_W'(4): begin
        frame.register_address = ssd_pkg::ADDR_DISPTEST;
        frame.register_data    = 8'h00;
      end
      default: begin
        frame.register_address = 4'(frame_r - ssd_pkg::FRAME_W'(4));
        frame.register_data    = rows_r[row_sel[ssd_pkg::ROW_IDX_W-1:0]];
      end
    endcase
  end

  assign frame_load = (state_r == ST_REFRESH) && (!out_valid_r || !out_stall);
  assign pop        = (state_r == ST_IDLE) && head.valid;
  assign rows_clear = pop && (head.item.operation == ssd_pkg::OP_CLEAR);

  // Command sequencer.
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    pos_nxt       = pos_r;
    frame_nxt     = frame_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          num_nxt   = head.item.number;
          pos_nxt   = head.item.end_position;
          frame_nxt = '0;
          if (head.item.operation == ssd_pkg::OP_PRINT) begin
            state_nxt = ST_PRINT;
          end else if (head.item.operation == ssd_pkg::OP_REFRESH) begin
            state_nxt = ST_REFRESH;
          end
        end
      end
      ST_PRINT: begin
        num_nxt = quot;
        pos_nxt = pos_r - 1'b1;
        if (quot == '0 || pos_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REFRESH: begin
        if (frame_load) begin
          out_valid_nxt = 1'b1;
          frame_nxt     = frame_r + 1'b1;
          if (frame_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      frame_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      frame_r     <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    pos_r <= pos_nxt;
    if (frame_load) begin
      out_data_r <= frame;
    end
  end

  // Segment buffer: cleared by reset and by the clear command.
  always_ff @(posedge clk) begin
    if (!rst_n || rows_clear) begin
      for (int i = 0; i < ssd_pkg::ROW_COUNT; i++) begin
        rows_r[i] <= 8'h00;
      end
    end else if (row_write) begin
      rows_r[pos_r[ssd_pkg::ROW_IDX_W-1:0]] <= ssd_pkg::seg_of_digit(digit);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/seven_segment_decimal_display_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment decimal display driver
// Keeps an eight-row segment buffer, prints decimal numbers into it and
// emits the register frames that refresh a display controller.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   operation, number, end_position
//   out_     output     out_valid / out_stall register_address, register_data,
//                                             last_frame
//   cfg_     input      APB psel / penable    brightness, scan_limit
//
// A transaction passes a holding register and a two-entry queue before the back
// end takes it. A clear needs nothing beyond being taken; print writes one digit
// per cycle (one to five digits, fewer when the digits run past row zero) and
// refresh sends thirteen frames, one per cycle through the output register
// while the output does not stall.
// Reset is synchronous and clears the buffer and the queue.
// A stall on the output holds the refresh sequence; the queue lets the
// input keep taking transactions until it fills.
// ----------------------------------------------------------------------------
module seven_segment_decimal_display_driver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ssd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ssd_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0]     brightness_r;
  logic [2:0]     scan_limit_r;
  logic           cfg_write;
  ssd_pkg::cfg_t  cfg;
  ssd_pkg::push_t push;
  ssd_pkg::head_t head;
  logic           queue_full;
  logic           pop;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 4'd1;
      scan_limit_r <= 3'd7;
    end else if (cfg_write) begin
      if (paddr[2] == ssd_pkg::REG_BRIGHTNESS) begin
        brightness_r <= pwdata[3:0];
      end else begin
        scan_limit_r <= pwdata[2:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      ssd_pkg::REG_BRIGHTNESS: prdata = {28'h0, brightness_r};
      default:                 prdata = {29'h0, scan_limit_r};
    endcase
  end

  assign cfg.brightness = brightness_r;
  assign cfg.scan_limit = scan_limit_r;

  ssd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push)
  );

  ssd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (queue_full),
    .head  (head),
    .pop   (pop)
  );

  ssd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display driver testbench
// Sends clear, print and refresh transactions to the display driver and keeps
// its own copy of the segment buffer and the two settings. Every refresh frame
// that leaves the block is checked in order against the predicted frames. Both
// channels pause and stall at random, and the settings are changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import ssd_pkg::*;

  localparam int         HALF_PERIOD   = 4;
  localparam int         SETTLE_CYCLES = 64;
  localparam int         RUN_LIMIT_NS  = 4_000_000;
  localparam int         PHASE_ITEMS   = 150;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted buffer, settings and the frames still owed by the block.
  logic [7:0]  buffer_rows [ROW_COUNT];
  logic [3:0]  brightness_setting;
  logic [2:0]  scan_limit_setting;
  out_item_t   frame_q [$];
  out_item_t   expected_frame;
  int          error_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  seven_segment_decimal_display_driver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Segment pattern of one decimal digit, segment A in bit 6.
  function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
    case (digit)
      4'd0:    return 8'h7E;
      4'd1:    return 8'h30;
      4'd2:    return 8'h6D;
      4'd3:    return 8'h79;
      4'd4:    return 8'h33;
      4'd5:    return 8'h5B;
      4'd6:    return 8'h5F;
      4'd7:    return 8'h72;
      4'd8:    return 8'h7F;
      default: return 8'h7B;
    endcase
  endfunction

  function automatic in_item_t make_command(input logic [1:0] op, input logic [15:0] num,
                                            input logic [2:0] end_row);
    in_item_t cmd;
    cmd.operation    = op;
    cmd.number       = num;
    cmd.end_position = end_row;
    return cmd;
  endfunction

  task automatic push_frame(input logic [3:0] addr, input logic [7:0] data,
                            input logic last);
    out_item_t frame;
    frame.register_address = addr;
    frame.register_data    = data;
    frame.last_frame       = last;
    frame_q.push_back(frame);
  endtask

  // Applies one accepted transaction to the predicted buffer and queues the
  // frames that a refresh owes.
  task automatic predict_command(input in_item_t cmd);
    int         row;
    logic [15:0] value;
    logic [3:0] row_addr;
    case (cmd.operation)
      OP_CLEAR: begin
        for (int i = 0; i < ROW_COUNT; i++) buffer_rows[i] = 8'h00;
      end
      OP_PRINT: begin
        // Least significant digit first, moving left; digits that would land
        // left of row zero are dropped.
        value = cmd.number;
        row   = int'(cmd.end_position);
        do begin
          if (row >= 0 && row < ROW_COUNT)
            buffer_rows[row] = digit_pattern(4'(value % 16'd10));
          value = value / 16'd10;
          row--;
        end while (value != 0 && row >= 0);
      end
      OP_REFRESH: begin
        push_frame(ADDR_DECODE, 8'h00, 1'b0);
        push_frame(ADDR_INTENSITY, {4'h0, brightness_setting}, 1'b0);
        push_frame(ADDR_SCANLIMIT, {5'h00, scan_limit_setting}, 1'b0);
        push_frame(ADDR_SHUTDOWN, 8'h01, 1'b0);
        push_frame(ADDR_DISPTEST, 8'h00, 1'b0);
        for (int i = 0; i < ROW_COUNT; i++) begin
          row_addr = 4'(i + 1);
          push_frame(row_addr, buffer_rows[ROW_COUNT - 1 - i], i == ROW_COUNT - 1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Receiver side: random stall, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Each accepted frame is compared with the oldest predicted one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected frame, expected none, actual %0h/%0h/%0b", $time,
                 out_data.register_address, out_data.register_data,
                 out_data.last_frame);
      end else begin
        expected_frame = frame_q.pop_front();
        if (out_data.register_address !== expected_frame.register_address)
          note_mismatch("register_address", {4'h0, expected_frame.register_address},
                        {4'h0, out_data.register_address});
        if (out_data.register_data !== expected_frame.register_data)
          note_mismatch("register_data", expected_frame.register_data,
                        out_data.register_data);
        if (out_data.last_frame !== expected_frame.last_frame)
          note_mismatch("last_frame", {7'h00, expected_frame.last_frame},
                        {7'h00, out_data.last_frame});
      end
    end
  end

  // Sends one transaction, with random idle cycles ahead of it, and predicts
  // its effect once it is accepted.
  task automatic send_command(input in_item_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(cmd);
  endtask

  // Holds the input off until every owed frame has arrived, then lets the
  // block finish any clear or print still in its queue.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // edge where the access completes.
  task automatic write_register(input logic index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == REG_BRIGHTNESS)
      brightness_setting = value[3:0];
    else
      scan_limit_setting = value[2:0];
  endtask

  function automatic in_item_t random_command();
    int          pick;
    logic [1:0]  op;
    logic [15:0] num;
    pick = int'($urandom_range(99));
    num  = 16'($urandom);
    // Mostly shorter numbers so that every digit count turns up often.
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(4))
        0:       num = 16'($urandom_range(9));
        1:       num = 16'($urandom_range(99));
        2:       num = 16'($urandom_range(999));
        3:       num = 16'($urandom_range(9999));
        default: num = 16'($urandom_range(65535));
      endcase
    end
    if (pick < 8)
      op = OP_CLEAR;
    else if (pick < 12)
      op = OP_UNUSED;
    else if (pick < 45)
      op = OP_REFRESH;
    else
      op = OP_PRINT;
    return make_command(op, num, 3'($urandom_range(7)));
  endfunction

  // A refresh straight after reset shows a blank buffer and the reset settings.
  task automatic test_reset_state();
    send_command(make_command(OP_REFRESH, 16'h0000, 3'd0));
  endtask

  // Zero, the largest number, every digit, overlapping prints and digits that
  // fall left of row zero.
  task automatic test_print_cases();
    send_command(make_command(OP_PRINT, 16'd0, 3'd7));
    send_command(make_command(OP_REFRESH, 16'hFFFF, 3'd7));
    send_command(make_command(OP_PRINT, 16'd65535, 3'd7));
    send_command(make_command(OP_REFRESH, 16'h0000, 3'd0));
    send_command(make_command(OP_PRINT, 16'd12345, 3'd2));
    send_command(make_command(OP_REFRESH, 16'h5555, 3'd5));
    send_command(make_command(OP_PRINT, 16'd9, 3'd0));
    send_command(make_command(OP_PRINT, 16'd43690, 3'd5));
    send_command(make_command(OP_PRINT, 16'd21845, 3'd4));
    send_command(make_command(OP_PRINT, 16'd60789, 3'd6));
    send_command(make_command(OP_REFRESH, 16'hAAAA, 3'd2));
  endtask

  // The unused operation code leaves the buffer alone; clear blanks it.
  task automatic test_unused_and_clear();
    send_command(make_command(OP_UNUSED, 16'hFFFF, 3'd7));
    send_command(make_command(OP_REFRESH, 16'h0000, 3'd0));
    send_command(make_command(OP_CLEAR, 16'hFFFF, 3'd7));
    send_command(make_command(OP_REFRESH, 16'h0000, 3'd0));
  endtask

  // Both settings at their extremes, each shown by a refresh.
  task automatic test_setting_extremes();
    send_command(make_command(OP_PRINT, 16'd808, 3'd3));
    pause_until_drained();
    write_register(REG_BRIGHTNESS, 32'd15);
    write_register(REG_SCAN_LIMIT, 32'd0);
    send_command(make_command(OP_REFRESH, 16'h0000, 3'd0));
    pause_until_drained();
    write_register(REG_BRIGHTNESS, 32'd0);
    write_register(REG_SCAN_LIMIT, 32'd7);
    send_command(make_command(OP_REFRESH, 16'h0000, 3'd0));
    pause_until_drained();
  endtask

  // Random transactions under one idling pattern, with fresh settings first.
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    pause_until_drained();
    write_register(REG_BRIGHTNESS, $urandom_range(15));
    write_register(REG_SCAN_LIMIT, $urandom_range(7));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_command(random_command());
  endtask

  initial begin
    for (int i = 0; i < ROW_COUNT; i++) buffer_rows[i] = 8'h00;
    brightness_setting = 4'd1;
    scan_limit_setting = 3'd7;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_print_cases();
    test_unused_and_clear();
    test_setting_extremes();
    test_random_phase(33, 72, PHASE_ITEMS);
    test_random_phase(72, 33, PHASE_ITEMS);
    test_random_phase(0, 0, PHASE_ITEMS);
    pause_until_drained();
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #RUN_LIMIT_NS;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
